// File: rtl/quaternion_vector_rotate_assert.svh
// ============================================================================
// quaternion_vector_rotate_assert.svh - assertion macros
// Clocked concurrent checks on clock, disabled while reset is high.
// ============================================================================
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

// Check cons in the same cycle as cond.
`define QVR_ASSERT_NOW(name, cond, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after cond.
`define QVR_ASSERT_NEXT(name, cond, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/qvr_pkg.sv
// ============================================================================
// qvr_pkg - shared types and constants of the quaternion vector rotator
// Field widths, internal arithmetic widths, register indexes, pipeline types.
// ============================================================================
package qvr_pkg;

   localparam int COORD_W   = 24;               // vector coordinate width
   localparam int QUAT_W    = 16;               // quaternion component, Q2.14
   localparam int QPROD_W   = 2 * QUAT_W;       // product of two components
   localparam int COEF_W    = QPROD_W + 1;      // matrix entry, Q5.28
   localparam int CL_W      = 16;               // low (unsigned) slice of an entry
   localparam int CH_W      = COEF_W - CL_W;    // high (signed) slice of an entry
   localparam int PH_W      = CH_W + COORD_W;   // high partial product
   localparam int PL_W      = CL_W + 1 + COORD_W; // low partial product
   localparam int HSUM_W    = PH_W + 2;
   localparam int ROUND_POS = 26;               // half of one output LSB
   localparam int FRAC_SHIFT = 27;              // Q28 scale, times two
   localparam int LSUM_W    = (PL_W + 2 > ROUND_POS + 2) ? PL_W + 2 : ROUND_POS + 2;
   localparam int TOT_W     = ((HSUM_W + CL_W > LSUM_W) ? HSUM_W + CL_W : LSUM_W) + 1;
   localparam int TERM_W    = TOT_W - FRAC_SHIFT;
   localparam int SAT_W     = TERM_W + 1;

   localparam int NUM_STAGES    = 5;
   localparam int SETTLE_CYCLES = 2;
   localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

   localparam int CSR_IDX_W = 8;
   localparam int TDATA_W   = ((3 * COORD_W + 7) / 8) * 8;

   typedef logic signed [QUAT_W-1:0]  quat_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [PH_W-1:0]    ph_type;
   typedef logic signed [PL_W-1:0]    pl_type;
   typedef logic signed [HSUM_W-1:0]  hsum_type;
   typedef logic signed [LSUM_W-1:0]  lsum_type;
   typedef logic signed [TERM_W-1:0]  term_type;

   typedef coord_type vec_type      [3];
   typedef coef_type  coef_mat_type [3][3];
   typedef ph_type    ph_mat_type   [3][3];
   typedef pl_type    pl_mat_type   [3][3];
   typedef hsum_type  hsum_vec_type [3];
   typedef lsum_type  lsum_vec_type [3];
   typedef term_type  term_vec_type [3];

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;   // stage k takes a new beat (or a bubble)
   } pipe_ctl_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_QUAT_W = CSR_IDX_W'(0),
      REG_QUAT_X = CSR_IDX_W'(1),
      REG_QUAT_Y = CSR_IDX_W'(2),
      REG_QUAT_Z = CSR_IDX_W'(3)
   } csr_reg_type;

   localparam quat_type QUAT_W_RESET = QUAT_W'(16384);
   localparam quat_type QUAT_V_RESET = QUAT_W'(0);

   localparam lsum_type  ROUND_HALF = LSUM_W'(1) << ROUND_POS;
   localparam coord_type COORD_HI   = COORD_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
   localparam coord_type COORD_LO   = COORD_W'(-(64'sd1 <<< (COORD_W - 1)));

endpackage

// File: rtl/qvr_coef.sv
// ============================================================================
// qvr_coef - quaternion registers and rotation matrix coefficients
// Holds the four components and derives the nine Q5.28 matrix entries
// over two register stages; flags the entries as settling after a write.
// ============================================================================
module qvr_coef (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [qvr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qvr_pkg::QUAT_W-1:0]  csr_data,
   output qvr_pkg::coef_mat_type       coef,
   output logic                        busy
);
   import qvr_pkg::*;

   quat_type qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [QPROD_W-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [QPROD_W-1:0] wx_ff, wy_ff, wz_ff;
   coef_mat_type coef_ff;
   logic [SETTLE_W-1:0] settle_ff, settle_in;

   assign csr_ready = 1'b1;

   // restart the settle count on every write, count down otherwise
   always_comb begin
      if (csr_valid) begin
         settle_in = SETTLE_W'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_W'(1);
      end else begin
         settle_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qw_ff     <= QUAT_W_RESET;
         qx_ff     <= QUAT_V_RESET;
         qy_ff     <= QUAT_V_RESET;
         qz_ff     <= QUAT_V_RESET;
         settle_ff <= SETTLE_W'(SETTLE_CYCLES);
      end else begin
         settle_ff <= settle_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_QUAT_W: qw_ff <= csr_data;
               REG_QUAT_X: qx_ff <= csr_data;
               REG_QUAT_Y: qy_ff <= csr_data;
               REG_QUAT_Z: qz_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // component products, then the matrix entries
   always_ff @(posedge clock) begin
      xx_ff <= qx_ff * qx_ff;
      yy_ff <= qy_ff * qy_ff;
      zz_ff <= qz_ff * qz_ff;
      xy_ff <= qx_ff * qy_ff;
      xz_ff <= qx_ff * qz_ff;
      yz_ff <= qy_ff * qz_ff;
      wx_ff <= qw_ff * qx_ff;
      wy_ff <= qw_ff * qy_ff;
      wz_ff <= qw_ff * qz_ff;

      coef_ff[0][0] <= -(COEF_W'(yy_ff) + COEF_W'(zz_ff));
      coef_ff[0][1] <= COEF_W'(xy_ff) - COEF_W'(wz_ff);
      coef_ff[0][2] <= COEF_W'(xz_ff) + COEF_W'(wy_ff);
      coef_ff[1][0] <= COEF_W'(xy_ff) + COEF_W'(wz_ff);
      coef_ff[1][1] <= -(COEF_W'(xx_ff) + COEF_W'(zz_ff));
      coef_ff[1][2] <= COEF_W'(yz_ff) - COEF_W'(wx_ff);
      coef_ff[2][0] <= COEF_W'(xz_ff) - COEF_W'(wy_ff);
      coef_ff[2][1] <= COEF_W'(yz_ff) + COEF_W'(wx_ff);
      coef_ff[2][2] <= -(COEF_W'(xx_ff) + COEF_W'(yy_ff));
   end

   assign coef = coef_ff;
   assign busy = (settle_ff != '0);

endmodule

// File: rtl/qvr_mult.sv
// ============================================================================
// qvr_mult - input register and partial product stage
// Splits each entry into a signed high and an unsigned low slice and
// multiplies both by the matching coordinate.
// ============================================================================
module qvr_mult (
   input  logic                  clock,
   input  qvr_pkg::pipe_ctl_type ctl,
   input  qvr_pkg::vec_type      vec_in,
   input  qvr_pkg::coef_mat_type coef,
   output qvr_pkg::ph_mat_type   ph,
   output qvr_pkg::pl_mat_type   pl,
   output qvr_pkg::vec_type      vec_out
);
   import qvr_pkg::*;

   vec_type    v1_ff, v2_ff;
   ph_mat_type ph_ff;
   pl_mat_type pl_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         v1_ff <= vec_in;
      end
      if (ctl.load[1]) begin
         v2_ff <= v1_ff;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               ph_ff[i][j] <= $signed(coef[i][j][COEF_W-1:CL_W]) * v1_ff[j];
               pl_ff[i][j] <= $signed({1'b0, coef[i][j][CL_W-1:0]}) * v1_ff[j];
            end
         end
      end
   end

   assign ph      = ph_ff;
   assign pl      = pl_ff;
   assign vec_out = v2_ff;

endmodule

// File: rtl/qvr_sum.sv
// ============================================================================
// qvr_sum - row accumulation and rounding
// Adds the partial products of each row, then joins the high and low sums
// and drops the fraction, rounding half up.
// ============================================================================
module qvr_sum (
   input  logic                  clock,
   input  qvr_pkg::pipe_ctl_type ctl,
   input  qvr_pkg::ph_mat_type   ph,
   input  qvr_pkg::pl_mat_type   pl,
   input  qvr_pkg::vec_type      vec_in,
   output qvr_pkg::term_vec_type term,
   output qvr_pkg::vec_type      vec_out
);
   import qvr_pkg::*;

   hsum_vec_type hsum_ff;
   lsum_vec_type lsum_ff;
   term_vec_type term_ff;
   vec_type      v3_ff, v4_ff;
   logic signed [TOT_W-1:0] total [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         total[i] = (TOT_W'(hsum_ff[i]) <<< CL_W) + TOT_W'(lsum_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         v3_ff <= vec_in;
         for (int i = 0; i < 3; i++) begin
            hsum_ff[i] <= HSUM_W'(ph[i][0]) + HSUM_W'(ph[i][1]) + HSUM_W'(ph[i][2]);
            // fold in the rounding half here, where the adder has room
            lsum_ff[i] <= LSUM_W'(pl[i][0]) + LSUM_W'(pl[i][1]) + LSUM_W'(pl[i][2])
                          + ROUND_HALF;
         end
      end
      if (ctl.load[3]) begin
         v4_ff <= v3_ff;
         for (int i = 0; i < 3; i++) begin
            term_ff[i] <= total[i][TOT_W-1:FRAC_SHIFT];
         end
      end
   end

   assign term    = term_ff;
   assign vec_out = v4_ff;

endmodule

// File: rtl/qvr_sat.sv
// ============================================================================
// qvr_sat - final add and saturation
// Adds the rotation term to the original coordinate, clamps to the
// coordinate range and flags any clamp.
// ============================================================================
module qvr_sat (
   input  logic                  clock,
   input  qvr_pkg::pipe_ctl_type ctl,
   input  qvr_pkg::term_vec_type term,
   input  qvr_pkg::vec_type      vec_in,
   output qvr_pkg::vec_type      rot,
   output logic                  clipped
);
   import qvr_pkg::*;

   localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(COORD_HI);
   localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(COORD_LO);

   logic signed [SAT_W-1:0] sum [3];
   coord_type  rot_in [3];
   logic [2:0] clip_in;
   vec_type    rot_ff;
   logic       clip_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = SAT_W'(term[i]) + SAT_W'(vec_in[i]);
         if (sum[i] > SAT_HI) begin
            rot_in[i]  = COORD_HI;
            clip_in[i] = 1'b1;
         end else if (sum[i] < SAT_LO) begin
            rot_in[i]  = COORD_LO;
            clip_in[i] = 1'b1;
         end else begin
            rot_in[i]  = sum[i][COORD_W-1:0];
            clip_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         rot_ff  <= rot_in;
         clip_ff <= |clip_in;
      end
   end

   assign rot     = rot_ff;
   assign clipped = clip_ff;

endmodule

// File: rtl/quaternion_vector_rotate.sv
// ============================================================================
// quaternion_vector_rotate - stream rotator of 3-D vectors by a quaternion
// Rotates every vector beat by the unit quaternion in four control registers.
// ============================================================================
// Usage:
//   Write quat_w, quat_x, quat_y, quat_z (Q2.14) on the csr channel, index
//   0..3; other indexes are dropped. csr_ready is always high. Write only
//   while no vector is in flight.
//   Send vectors on req (x, y, z packed from bit 0), take results on rsp:
//   rot_x, rot_y, rot_z in rsp_tdata, the saturation flag in rsp_tuser.
//   Throughput: one vector per clock while rsp_tready is high and the
//   coefficients are not being rebuilt, set by the five-stage pipeline
//   (input reg, partial products, row sums, round, add/saturate).
//   After reset and after every register write, req_tready stays low
//   while the matrix coefficients are rebuilt.
//   A stalled receiver holds the rsp beat; bubbles inside the pipeline
//   still close up; the stall drops req_tready only once every stage is full.
//   Reset (synchronous, active high) empties the pipeline, restores identity.
// ============================================================================
`include "quaternion_vector_rotate_assert.svh"

module quaternion_vector_rotate (
   input  logic                          clock,
   input  logic                          reset,
   // slave side: vec_x, vec_y, vec_z from bit 0 up
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [qvr_pkg::TDATA_W-1:0]   req_tdata,
   // master side: rot_x, rot_y, rot_z from bit 0 up
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [qvr_pkg::TDATA_W-1:0]   rsp_tdata,
   // master side: clipped
   output logic                          rsp_tuser,
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [qvr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [qvr_pkg::QUAT_W-1:0]    csr_data
);
   import qvr_pkg::*;

   coef_mat_type  coef;
   logic          busy;
   vec_type       req_vec, vec2, vec4, rot;
   ph_mat_type    ph;
   pl_mat_type    pl;
   term_vec_type  term;
   logic          clipped;
   pipe_ctl_type  ctl;

   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES:0]   rdy;
   logic                  pipe_full;
   logic                  rot_at_rail;

   // unpack the input beat
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         req_vec[j] = req_tdata[j*COORD_W +: COORD_W];
      end
   end

   // a stage advances when it is empty or its successor advances
   always_comb begin
      rdy[NUM_STAGES] = rsp_tready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_comb begin
      vld_in[0] = rdy[0] ? (req_tvalid && !busy) : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ctl.load   = rdy[NUM_STAGES-1:0];
   assign req_tready = rdy[0] && !busy;     // hold off while coefficients settle
   assign rsp_tvalid = vld_ff[NUM_STAGES-1];
   assign rsp_tdata  = TDATA_W'({rot[2], rot[1], rot[0]});
   assign rsp_tuser  = clipped;

   assign pipe_full   = &vld_ff;
   assign rot_at_rail = (rot[0] == COORD_HI) || (rot[0] == COORD_LO) ||
                        (rot[1] == COORD_HI) || (rot[1] == COORD_LO) ||
                        (rot[2] == COORD_HI) || (rot[2] == COORD_LO);

   qvr_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef),
      .busy      (busy)
   );

   qvr_mult u_mult (
      .clock   (clock),
      .ctl     (ctl),
      .vec_in  (req_vec),
      .coef    (coef),
      .ph      (ph),
      .pl      (pl),
      .vec_out (vec2)
   );

   qvr_sum u_sum (
      .clock   (clock),
      .ctl     (ctl),
      .ph      (ph),
      .pl      (pl),
      .vec_in  (vec2),
      .term    (term),
      .vec_out (vec4)
   );

   qvr_sat u_sat (
      .clock   (clock),
      .ctl     (ctl),
      .term    (term),
      .vec_in  (vec4),
      .rot     (rot),
      .clipped (clipped)
   );

   // no vector may enter while the coefficients rebuild after a write
   `QVR_ASSERT_NEXT(a_settle_after_write, csr_valid && csr_ready, !req_tready, "vector in settle")

   // a full pipeline facing a stalled receiver takes nothing
   `QVR_ASSERT_NOW(a_full_stall, pipe_full && !rsp_tready, !req_tready, "input taken while full")

   // a clip flag means some coordinate sits on a rail
   `QVR_ASSERT_NOW(a_clip_at_rail, rsp_tvalid && rsp_tuser, rot_at_rail, "clip off the rails")

endmodule
